// ===== rtl/cpsd_pkg.sv =====
// Package for the channel power spike debounce block.
// Holds sizes, operation codes, register indexes and the records shared between the modules.
// Depends on nothing.
package cpsd_pkg;

  localparam int CHANNELS    = 128;
  localparam int EVENT_DEPTH = 16;

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EV_W     = $clog2(EVENT_DEPTH);
  localparam int EV_SLOTS = 1 << EV_W;
  localparam int RING_AW  = CH_W + EV_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 136;

  localparam logic [15:0] THRESHOLD_RST = 16'd300;
  localparam logic [15:0] PERIOD_RST    = 16'd3;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    REG_SPIKE_THRESHOLD = 1'b0,
    REG_SETTLE_PERIOD   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    func_e       func;
    logic [6:0]  channel;
    logic [15:0] power;
    logic [15:0] snr;
    logic [31:0] stamp;
    logic [3:0]  slot;
  } item_t;

  typedef struct packed {
    logic                power_known;
    logic [15:0]         acc_power;
    logic [15:0]         acc_snr;
    logic [31:0]         acc_time;
    logic                marks_known;
    logic [15:0]         low_mark;
    logic [15:0]         high_mark;
    logic [EV_W-1:0]     wr_pos;
    logic [EV_SLOTS-1:0] slot_used;
  } row_t;

  typedef struct packed {
    logic [15:0] prev_power;
    logic [15:0] new_power;
    logic [31:0] stamp;
  } ring_t;

  typedef struct packed {
    logic        spike;
    logic        power_valid;
    logic [15:0] debounced_power;
    logic [15:0] debounced_snr;
    logic        marks_valid;
    logic [15:0] low_mark;
    logic [15:0] high_mark;
    logic        event_valid;
    logic [15:0] event_prev_power;
    logic [15:0] event_new_power;
    logic [31:0] event_time;
  } result_t;

  typedef struct packed {
    logic               row_we;
    logic               ring_we;
    logic [EV_W-1:0]    ring_pos;
  } wb_ctl_t;

endpackage

// ===== rtl/cpsd_chan_store.sv =====
// Per-channel state memory with a valid bit for each row and write-to-read forwarding.
// A row never written since reset reads as all zero.
// Depends on cpsd_pkg.
module cpsd_chan_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [cpsd_pkg::CH_W-1:0]   rd_ch_i,
  input  logic                        we_i,
  input  logic [cpsd_pkg::CH_W-1:0]   wr_ch_i,
  input  cpsd_pkg::row_t              wr_row_i,
  output cpsd_pkg::row_t              row_o
);

  cpsd_pkg::row_t mem [cpsd_pkg::CHANNELS];
  logic [cpsd_pkg::CHANNELS-1:0] row_vld_q;
  cpsd_pkg::row_t row_q;
  logic           hit_vld_q;
  logic           fwd;

  assign fwd = we_i && (wr_ch_i == rd_ch_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_ch_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      row_q <= fwd ? wr_row_i : mem[rd_ch_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      hit_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        row_vld_q[wr_ch_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_vld_q <= fwd || row_vld_q[rd_ch_i];
      end
    end
  end

  assign row_o = hit_vld_q ? row_q : '0;

endmodule

// ===== rtl/cpsd_ring_store.sv =====
// Event ring memory, one block of slots per channel, with write-to-read forwarding.
// Depends on cpsd_pkg.
module cpsd_ring_store (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [cpsd_pkg::RING_AW-1:0]   rd_addr_i,
  input  logic                           we_i,
  input  logic [cpsd_pkg::RING_AW-1:0]   wr_addr_i,
  input  cpsd_pkg::ring_t                wr_data_i,
  output cpsd_pkg::ring_t                rd_data_o
);

  cpsd_pkg::ring_t mem [1 << cpsd_pkg::RING_AW];
  cpsd_pkg::ring_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= (we_i && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/cpsd_update.sv =====
// Combinational update for one word: spike test, acceptance, watermarks, ring logging, clear and slot read.
// Produces the new channel row, the ring write and the result word.
// Depends on cpsd_pkg.
module cpsd_update (
  input  cpsd_pkg::item_t    item_i,
  input  cpsd_pkg::row_t     row_i,
  input  cpsd_pkg::ring_t    ring_i,
  input  logic [15:0]        threshold_i,
  input  logic [15:0]        period_i,
  output cpsd_pkg::wb_ctl_t  ctl_o,
  output cpsd_pkg::row_t     row_o,
  output cpsd_pkg::ring_t    ring_o,
  output cpsd_pkg::result_t  res_o
);

  logic [16:0]                   diff;
  logic [16:0]                   adiff;
  logic [31:0]                   dt;
  logic                          is_spike;
  logic                          ch_ok;
  logic                          slot_ok;
  logic [cpsd_pkg::EV_W-1:0]     slot_idx;
  cpsd_pkg::row_t                nxt;

  assign diff     = {item_i.power[15], item_i.power} - {row_i.acc_power[15], row_i.acc_power};
  assign adiff    = diff[16] ? (17'd0 - diff) : diff;
  assign dt       = item_i.stamp - row_i.acc_time;
  assign is_spike = row_i.power_known && (adiff > {1'b0, threshold_i})
                    && (dt < {16'd0, period_i});
  assign ch_ok    = 32'(item_i.channel) < cpsd_pkg::CHANNELS;
  assign slot_ok  = 32'(item_i.slot) < cpsd_pkg::EVENT_DEPTH;
  assign slot_idx = cpsd_pkg::EV_W'(item_i.slot);

  always_comb begin
    nxt          = row_i;
    ctl_o        = '0;
    ctl_o.ring_pos = row_i.wr_pos;
    ring_o.prev_power = row_i.acc_power;
    ring_o.new_power  = item_i.power;
    ring_o.stamp      = item_i.stamp;
    res_o        = '0;

    unique case (item_i.func)
      cpsd_pkg::FUNC_UPDATE: begin
        ctl_o.row_we = 1'b1;
        if (is_spike) begin
          ctl_o.ring_we = 1'b1;
          res_o.spike   = 1'b1;
          nxt.slot_used[row_i.wr_pos] = 1'b1;
          if (row_i.wr_pos == cpsd_pkg::EV_W'(cpsd_pkg::EVENT_DEPTH - 1)) begin
            nxt.wr_pos = '0;
          end else begin
            nxt.wr_pos = row_i.wr_pos + cpsd_pkg::EV_W'(1);
          end
        end else begin
          nxt.power_known = 1'b1;
          nxt.acc_power   = item_i.power;
          nxt.acc_snr     = item_i.snr;
          nxt.acc_time    = item_i.stamp;
          nxt.marks_known = 1'b1;
          if (!row_i.marks_known || ($signed(item_i.power) < $signed(row_i.low_mark))) begin
            nxt.low_mark = item_i.power;
          end
          if (!row_i.marks_known || ($signed(item_i.power) > $signed(row_i.high_mark))) begin
            nxt.high_mark = item_i.power;
          end
        end
      end
      cpsd_pkg::FUNC_CLEAR: begin
        ctl_o.row_we    = 1'b1;
        nxt.marks_known = 1'b0;
        nxt.slot_used   = '0;
        nxt.wr_pos      = '0;
      end
      cpsd_pkg::FUNC_READ: begin
        if (slot_ok && row_i.slot_used[slot_idx]) begin
          res_o.event_valid      = 1'b1;
          res_o.event_prev_power = ring_i.prev_power;
          res_o.event_new_power  = ring_i.new_power;
          res_o.event_time       = ring_i.stamp;
        end
      end
      default: begin
      end
    endcase

    if (nxt.power_known) begin
      res_o.power_valid     = 1'b1;
      res_o.debounced_power = nxt.acc_power;
      res_o.debounced_snr   = nxt.acc_snr;
    end
    if (nxt.marks_known) begin
      res_o.marks_valid = 1'b1;
      res_o.low_mark    = nxt.low_mark;
      res_o.high_mark   = nxt.high_mark;
    end

    if (!ch_ok) begin
      res_o         = '0;
      ctl_o.row_we  = 1'b0;
      ctl_o.ring_we = 1'b0;
    end
    row_o = nxt;
  end

endmodule

// ===== rtl/channel_power_spike_debounce.sv =====
// Top level of the channel power spike debounce block.
// Input register, channel and ring memories, update logic, result register, config registers.
// Depends on cpsd_pkg, cpsd_chan_store, cpsd_ring_store and cpsd_update.

// The block takes one word per clock cycle unless the output side stalls, and returns exactly
// one result word for each, through the input stage and result registers. The channel state
// memory is read at acceptance with registered data, and the update writes it back when the
// word leaves the input stage; a word that follows on the same channel picks up the written
// row through forwarding, so no stall cycles arise. The rate is set by the single read and
// write port of each memory. Configuration is to be written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while no word is in flight; the block itself does not enforce this.
module channel_power_spike_debounce (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel, power_sample, snr_sample, sample_time, slot; zero fill above.
  input  logic [cpsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func.
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // spike, power_valid, debounced_power, debounced_snr, marks_valid, low_mark, high_mark,
  // event_valid, event_prev_power, event_new_power, event_time; zero fill above.
  output logic [cpsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_idx_i,
  input  logic [15:0]                         cfg_wdata_i
);

  cpsd_pkg::item_t   in_item;
  cpsd_pkg::item_t   s1_item_q;
  logic              s1_vld_q;
  logic              s1_adv;
  logic              accept;
  cpsd_pkg::row_t    row_rd;
  cpsd_pkg::row_t    row_wr;
  cpsd_pkg::ring_t   ring_rd;
  cpsd_pkg::ring_t   ring_wr;
  cpsd_pkg::wb_ctl_t ctl;
  cpsd_pkg::result_t res;
  cpsd_pkg::result_t out_res_q;
  logic              out_vld_q;
  logic [15:0]       threshold_q;
  logic [15:0]       period_q;
  logic [cpsd_pkg::CH_W-1:0] s1_ch;

  assign in_item.func    = cpsd_pkg::func_e'(s_axis_tuser);
  assign in_item.channel = s_axis_tdata[6:0];
  assign in_item.power   = s_axis_tdata[22:7];
  assign in_item.snr     = s_axis_tdata[38:23];
  assign in_item.stamp   = s_axis_tdata[70:39];
  assign in_item.slot    = s_axis_tdata[74:71];

  assign s1_adv        = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s1_ch         = cpsd_pkg::CH_W'(s1_item_q.channel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= cpsd_pkg::THRESHOLD_RST;
      period_q    <= cpsd_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cpsd_pkg::cfg_reg_e'(cfg_idx_i))
        cpsd_pkg::REG_SPIKE_THRESHOLD: threshold_q <= cfg_wdata_i;
        cpsd_pkg::REG_SETTLE_PERIOD:   period_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  cpsd_chan_store u_chan_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_ch_i  (cpsd_pkg::CH_W'(in_item.channel)),
    .we_i     (s1_adv && ctl.row_we),
    .wr_ch_i  (s1_ch),
    .wr_row_i (row_wr),
    .row_o    (row_rd)
  );

  cpsd_ring_store u_ring_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i ({cpsd_pkg::CH_W'(in_item.channel), cpsd_pkg::EV_W'(in_item.slot)}),
    .we_i      (s1_adv && ctl.ring_we),
    .wr_addr_i ({s1_ch, ctl.ring_pos}),
    .wr_data_i (ring_wr),
    .rd_data_o (ring_rd)
  );

  cpsd_update u_update (
    .item_i      (s1_item_q),
    .row_i       (row_rd),
    .ring_i      (ring_rd),
    .threshold_i (threshold_q),
    .period_i    (period_q),
    .ctl_o       (ctl),
    .row_o       (row_wr),
    .ring_o      (ring_wr),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0,
                          out_res_q.event_time,
                          out_res_q.event_new_power,
                          out_res_q.event_prev_power,
                          out_res_q.event_valid,
                          out_res_q.high_mark,
                          out_res_q.low_mark,
                          out_res_q.marks_valid,
                          out_res_q.debounced_snr,
                          out_res_q.debounced_power,
                          out_res_q.power_valid,
                          out_res_q.spike};

  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_adv |=> m_axis_tvalid)
    else $error("Finished word did not reach the result register.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && res.spike) |-> (s1_item_q.func == cpsd_pkg::FUNC_UPDATE))
    else $error("Spike reported for an operation other than a sample update.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && res.event_valid) |-> (s1_item_q.func == cpsd_pkg::FUNC_READ))
    else $error("Event reported for an operation other than a slot read.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && ctl.ring_we) |-> (ctl.row_we && res.spike))
    else $error("Ring written without a spike and channel write-back.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !s1_adv)
    else $error("Input stage advanced into a stalled result register.");

endmodule
